### rtl/aafc_pkg.sv
`default_nettype none

package aafc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PIDX_W     = 3;
  localparam int COEF_W     = 32;
  localparam int BOX_W      = 20;
  localparam int MARGIN_W   = 17;
  localparam int PROD_W     = COEF_W + BOX_W;
  localparam int SUM_W      = PROD_W + 3;

  localparam logic signed [MARGIN_W-1:0] MARGIN_RESET  = -17'sd6554;
  localparam logic [PIDX_W-1:0]          VISIBLE_PLANE = PIDX_W'(NUM_PLANES);

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TEST = 1'b1
  } mode_e;

  // Request as it travels down the row of plane cells
  typedef struct packed {
    mode_e                    mode;
    logic [PIDX_W-1:0]        plane_index;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [BOX_W-1:0]  box_min_x;
    logic signed [BOX_W-1:0]  box_min_y;
    logic signed [BOX_W-1:0]  box_min_z;
    logic signed [BOX_W-1:0]  box_max_x;
    logic signed [BOX_W-1:0]  box_max_y;
    logic signed [BOX_W-1:0]  box_max_z;
    logic                     culled;
    logic [PIDX_W-1:0]        fail_idx;
  } item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic signed [COEF_W-1:0] offset;
  } prod_t;

  // p-vertex corner: max corner for a non-negative coefficient
  function automatic logic signed [BOX_W-1:0] pick_corner(
    input logic signed [COEF_W-1:0] coef,
    input logic signed [BOX_W-1:0]  lo,
    input logic signed [BOX_W-1:0]  hi
  );
    return coef[COEF_W-1] ? lo : hi;
  endfunction

endpackage

`default_nettype wire

### rtl/aafc_if.sv
`default_nettype none

interface aafc_req_if;
  import aafc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [PIDX_W-1:0]        plane_index;
  logic signed [COEF_W-1:0] coef_a;
  logic signed [COEF_W-1:0] coef_b;
  logic signed [COEF_W-1:0] coef_c;
  logic signed [COEF_W-1:0] coef_d;
  logic signed [BOX_W-1:0]  box_min_x;
  logic signed [BOX_W-1:0]  box_min_y;
  logic signed [BOX_W-1:0]  box_min_z;
  logic signed [BOX_W-1:0]  box_max_x;
  logic signed [BOX_W-1:0]  box_max_y;
  logic signed [BOX_W-1:0]  box_max_z;

  modport source (
    output valid, mode, plane_index, coef_a, coef_b, coef_c, coef_d,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, mode, plane_index, coef_a, coef_b, coef_c, coef_d,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface aafc_rsp_if;
  import aafc_pkg::*;

  logic              valid;
  logic              ready;
  logic              visible;
  logic [PIDX_W-1:0] failing_plane;

  modport source (
    output valid, visible, failing_plane,
    input  ready
  );

  modport sink (
    input  valid, visible, failing_plane,
    output ready
  );
endinterface

`default_nettype wire

### rtl/aafc_cell.sv
`default_nettype none

module aafc_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [aafc_pkg::PIDX_W-1:0]        plane_id_i,
  input  logic signed [aafc_pkg::SUM_W-1:0]  margin_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  aafc_pkg::item_t                    item_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output aafc_pkg::item_t                    item_o
);
  import aafc_pkg::*;

  logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;

  logic  mul_valid_q, mul_valid_d;
  item_t mul_item_q;
  prod_t mul_prod_q, mul_prod_d;

  logic  sum_valid_q, sum_valid_d;
  item_t sum_item_q, sum_item_d;

  logic                    sum_ready, mul_ready, take_in, take_mul, load_hit;
  logic signed [SUM_W-1:0] plane_sum;

  assign sum_ready = !sum_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || sum_ready;
  assign take_in   = valid_i && mul_ready;
  assign take_mul  = mul_valid_q && sum_ready;
  assign load_hit  = take_in && (item_i.mode == MODE_LOAD) &&
                     (item_i.plane_index == plane_id_i);

  // Multiply stage: weight the p-vertex with this cell's plane
  always_comb begin
    mul_prod_d.prod_x = PROD_W'(coef_a_q) *
                        PROD_W'(pick_corner(coef_a_q, item_i.box_min_x, item_i.box_max_x));
    mul_prod_d.prod_y = PROD_W'(coef_b_q) *
                        PROD_W'(pick_corner(coef_b_q, item_i.box_min_y, item_i.box_max_y));
    mul_prod_d.prod_z = PROD_W'(coef_c_q) *
                        PROD_W'(pick_corner(coef_c_q, item_i.box_min_z, item_i.box_max_z));
    mul_prod_d.offset = coef_d_q;
  end

  // Sum stage: keep the first culling plane only
  always_comb begin
    plane_sum = SUM_W'(mul_prod_q.prod_x) + SUM_W'(mul_prod_q.prod_y) +
                SUM_W'(mul_prod_q.prod_z) + SUM_W'(mul_prod_q.offset);
    sum_item_d = mul_item_q;
    if (mul_item_q.mode == MODE_TEST && !mul_item_q.culled && plane_sum < margin_i) begin
      sum_item_d.culled   = 1'b1;
      sum_item_d.fail_idx = plane_id_i;
    end
  end

  always_comb begin
    mul_valid_d = mul_valid_q;
    if (mul_ready) begin
      mul_valid_d = valid_i;
    end
    sum_valid_d = sum_valid_q;
    if (sum_ready) begin
      sum_valid_d = mul_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= mul_valid_d;
      sum_valid_q <= sum_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      coef_a_q <= item_i.coef_a;
      coef_b_q <= item_i.coef_b;
      coef_c_q <= item_i.coef_c;
      coef_d_q <= item_i.coef_d;
    end
    if (take_in) begin
      mul_item_q <= item_i;
      mul_prod_q <= mul_prod_d;
    end
    if (take_mul) begin
      sum_item_q <= sum_item_d;
    end
  end

  assign ready_o = mul_ready;
  assign valid_o = sum_valid_q;
  assign item_o  = sum_item_q;

endmodule

`default_nettype wire

### rtl/aabb_frustum_cull_core.sv
// Stages: 2*NUM_PLANES register stages plus the output register.
// Throughput: one request per cycle unless rsp_o.ready holds back a box result;
//   each plane cell has its own multipliers.
// Reset: rst_ni (async, active low) empties the pipeline and sets the margin to
//   -6554 (about -0.1); plane coefficients hold no reset value until loaded.
`default_nettype none

module aabb_frustum_cull_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic signed [aafc_pkg::MARGIN_W-1:0]  cfg_wdata_i,
  aafc_req_if.sink                              req_i,
  aafc_rsp_if.source                            rsp_o
);
  import aafc_pkg::*;

  // Cull margin, sign-extended once for all cells
  logic signed [MARGIN_W-1:0] margin_q;
  logic signed [SUM_W-1:0]    margin_ext;

  // Link between neighboring cells: index 0 is the request port,
  // index NUM_PLANES feeds the output register
  logic  link_valid [NUM_PLANES+1];
  logic  link_ready [NUM_PLANES+1];
  item_t link_item  [NUM_PLANES+1];

  logic              rsp_valid_q, rsp_valid_d;
  logic              visible_q;
  logic [PIDX_W-1:0] fail_q;
  logic              drain;

  assign margin_ext = SUM_W'(margin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  // Pack the incoming request; the cull result starts clear
  always_comb begin
    link_item[0].mode        = mode_e'(req_i.mode);
    link_item[0].plane_index = req_i.plane_index;
    link_item[0].coef_a      = req_i.coef_a;
    link_item[0].coef_b      = req_i.coef_b;
    link_item[0].coef_c      = req_i.coef_c;
    link_item[0].coef_d      = req_i.coef_d;
    link_item[0].box_min_x   = req_i.box_min_x;
    link_item[0].box_min_y   = req_i.box_min_y;
    link_item[0].box_min_z   = req_i.box_min_z;
    link_item[0].box_max_x   = req_i.box_max_x;
    link_item[0].box_max_y   = req_i.box_max_y;
    link_item[0].box_max_z   = req_i.box_max_z;
    link_item[0].culled      = 1'b0;
    link_item[0].fail_idx    = '0;
  end

  assign link_valid[0] = req_i.valid;
  assign req_i.ready   = link_ready[0];

  // One cell per plane. Loads travel the same row as tests, so a test always
  // sees every plane load that was accepted ahead of it.
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    aafc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .plane_id_i (PIDX_W'(g)),
      .margin_i   (margin_ext),
      .valid_i    (link_valid[g]),
      .ready_o    (link_ready[g]),
      .item_i     (link_item[g]),
      .valid_o    (link_valid[g+1]),
      .ready_i    (link_ready[g+1]),
      .item_o     (link_item[g+1])
    );
  end

  // Drop loads at the end of the row; hold a box result until taken
  assign link_ready[NUM_PLANES] = !rsp_valid_q || rsp_o.ready ||
                                  (link_item[NUM_PLANES].mode == MODE_LOAD);
  assign drain = link_valid[NUM_PLANES] && link_ready[NUM_PLANES];

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (drain && link_item[NUM_PLANES].mode == MODE_TEST) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain && link_item[NUM_PLANES].mode == MODE_TEST) begin
      visible_q <= !link_item[NUM_PLANES].culled;
      fail_q    <= link_item[NUM_PLANES].culled ? link_item[NUM_PLANES].fail_idx
                                                : VISIBLE_PLANE;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.visible       = visible_q;
  assign rsp_o.failing_plane = fail_q;

  // A culled box names a real plane, a visible one names the plane count
  a_fail_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (visible_q == (fail_q == VISIBLE_PLANE)))
    else $error("failing plane code disagrees with visibility");

  // A stalled box at the row end stays put
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_valid[NUM_PLANES] && !link_ready[NUM_PLANES]) |=>
    (link_valid[NUM_PLANES] && $stable(link_item[NUM_PLANES])))
    else $error("row end lost a stalled request");

  // Every box leaving the row becomes a response
  a_box_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain && link_item[NUM_PLANES].mode == MODE_TEST) |=> rsp_valid_q)
    else $error("box result dropped");

  // Margin write takes effect on the next cycle
  a_margin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (margin_q == $past(cfg_wdata_i)))
    else $error("margin write not captured");

endmodule

`default_nettype wire
